### src/rcp_pkg.sv
// Package for the RESP command parser: widths, codes and the result type.
package rcp_pkg;

   localparam int COUNT_BITS     = 16;
   localparam int LENGTH_BITS    = 32;
   localparam int ACCUM_BITS     = 32;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 31;

   localparam logic [ACCUM_BITS:0] COUNT_MAX  = (ACCUM_BITS+1)'((64'd1 << COUNT_BITS) - 64'd1);
   localparam logic [ACCUM_BITS:0] LENGTH_MAX = (ACCUM_BITS+1)'((64'd1 << LENGTH_BITS) - 64'd1);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_ARG_COUNT   = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_BULK_LENGTH = CSR_INDEX_BITS'(1);

   localparam logic [15:0] MAX_ARG_COUNT_RESET   = 16'd1024;
   localparam logic [30:0] MAX_BULK_LENGTH_RESET = 31'd536870912;

   localparam logic [3:0] PH_ARR_HDR  = 4'd0;
   localparam logic [3:0] PH_ARR_SKIP = 4'd1;
   localparam logic [3:0] PH_ARR_NUM  = 4'd2;
   localparam logic [3:0] PH_ARR_LF   = 4'd3;
   localparam logic [3:0] PH_BLK_HDR  = 4'd4;
   localparam logic [3:0] PH_BLK_SKIP = 4'd5;
   localparam logic [3:0] PH_BLK_NUM  = 4'd6;
   localparam logic [3:0] PH_BLK_LF   = 4'd7;
   localparam logic [3:0] PH_DATA     = 4'd8;
   localparam logic [3:0] PH_DATA_CR  = 4'd9;
   localparam logic [3:0] PH_DATA_LF  = 4'd10;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERR   = 2'd2;
   localparam logic [1:0] KIND_EMPTY = 2'd3;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_DOLAR = 8'h24;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [15:0] arg_index;
      logic        null_arg;
      logic        command_end;
   } result_type;

endpackage

### src/rcp_ifs.sv
// Valid/ready channel interfaces for request bytes and parser results.
interface rcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface rcp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  data_byte;
   logic [15:0] arg_index;
   logic        null_arg;
   logic        command_end;

   modport source (output valid, output kind, output data_byte, output arg_index,
                   output null_arg, output command_end, input ready);
   modport sink (input valid, input kind, input data_byte, input arg_index,
                 input null_arg, input command_end, output ready);
endinterface

### src/rcp_in_reg.sv
// Input register: holds one request byte until the parser takes it.
module rcp_in_reg
   import rcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   rcp_req_if.sink    req,
   input  logic       advance,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       take;

   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req.in_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

### src/rcp_core.sv
// Parser core: limit registers, parse state and next-state/result logic.
module rcp_core
   import rcp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      advance,
   input  logic [7:0]                byte_data,
   output logic                      res_valid,
   output result_type                res
);

   logic [15:0]            max_arg_count_ff;
   logic [30:0]            max_bulk_length_ff;

   logic [3:0]             phase_ff, phase_in;
   logic [ACCUM_BITS-1:0]  accum_ff, accum_in;
   logic                   negative_ff, negative_in;
   logic                   digit_seen_ff, digit_seen_in;
   logic                   line_started_ff, line_started_in;
   logic [COUNT_BITS-1:0]  args_expected_ff, args_expected_in;
   logic [COUNT_BITS-1:0]  args_done_ff, args_done_in;
   logic [LENGTH_BITS-1:0] bytes_left_ff, bytes_left_in;

   logic                   is_digit;
   logic [ACCUM_BITS+3:0]  accum_next;
   logic [ACCUM_BITS:0]    accum_ext;
   logic [COUNT_BITS:0]    done_plus;
   logic                   last_arg;
   logic                   do_fail, do_restart, do_clear, do_arg_end, arg_nul, take_ok;
   logic [LENGTH_BITS-1:0] bytes_dec;

   assign is_digit   = (byte_data >= CHAR_ZERO) && (byte_data <= CHAR_NINE);
   assign accum_next = ({4'd0, accum_ff} << 3) + ({4'd0, accum_ff} << 1)
                       + (ACCUM_BITS+4)'(byte_data - CHAR_ZERO);
   assign accum_ext  = {1'b0, accum_ff};
   assign done_plus  = {1'b0, args_done_ff} + (COUNT_BITS+1)'(1);
   assign last_arg   = done_plus == {1'b0, args_expected_ff};
   assign bytes_dec  = bytes_left_ff - LENGTH_BITS'(1);

   always_comb begin
      phase_in         = phase_ff;
      accum_in         = accum_ff;
      negative_in      = negative_ff;
      digit_seen_in    = digit_seen_ff;
      line_started_in  = line_started_ff;
      args_expected_in = args_expected_ff;
      args_done_in     = args_done_ff;
      bytes_left_in    = bytes_left_ff;
      res_valid        = 1'b0;
      res.kind         = KIND_DATA;
      res.data_byte    = 8'h00;
      res.arg_index    = 16'(args_done_ff);
      res.null_arg     = 1'b0;
      res.command_end  = 1'b0;
      do_fail          = 1'b0;
      do_restart       = 1'b0;
      do_clear         = 1'b0;
      do_arg_end       = 1'b0;
      arg_nul          = 1'b0;
      take_ok          = 1'b0;

      // number character: optional leading minus, then digits
      if ((phase_ff == PH_ARR_NUM || phase_ff == PH_BLK_NUM) && byte_data != CHAR_CR) begin
         if (byte_data == CHAR_MINUS && !line_started_ff) begin
            negative_in     = 1'b1;
            line_started_in = 1'b1;
            take_ok         = 1'b1;
         end else if (is_digit) begin
            accum_in        = (accum_next[ACCUM_BITS+3:ACCUM_BITS] != 4'd0) ?
                              '1 : accum_next[ACCUM_BITS-1:0];
            digit_seen_in   = 1'b1;
            line_started_in = 1'b1;
            take_ok         = 1'b1;
         end
      end

      unique case (phase_ff)
         PH_ARR_HDR: begin
            if (byte_data == CHAR_CR) begin
               phase_in = PH_ARR_SKIP;
            end else if (byte_data == CHAR_STAR) begin
               do_clear = 1'b1;
               phase_in = PH_ARR_NUM;
            end else begin
               do_fail = 1'b1;
            end
         end
         PH_ARR_SKIP: begin
            if (byte_data == CHAR_LF) phase_in = PH_ARR_HDR;
            else do_fail = 1'b1;
         end
         PH_ARR_NUM: begin
            if (byte_data == CHAR_CR) begin
               if (!digit_seen_ff || (negative_ff && accum_ff != '0) ||
                   accum_ext > {17'd0, max_arg_count_ff} || accum_ext > COUNT_MAX) begin
                  do_fail = 1'b1;
               end else begin
                  args_expected_in = COUNT_BITS'(accum_ff);
                  phase_in         = PH_ARR_LF;
               end
            end else if (!take_ok) begin
               do_fail = 1'b1;
            end
         end
         PH_ARR_LF: begin
            if (byte_data != CHAR_LF) begin
               do_fail = 1'b1;
            end else if (args_expected_ff == '0) begin
               do_restart      = 1'b1;
               res_valid       = 1'b1;
               res.kind        = KIND_EMPTY;
               res.arg_index   = 16'd0;
               res.command_end = 1'b1;
            end else begin
               args_done_in = '0;
               do_clear     = 1'b1;
               phase_in     = PH_BLK_HDR;
            end
         end
         PH_BLK_HDR: begin
            if (byte_data == CHAR_CR) begin
               phase_in = PH_BLK_SKIP;
            end else if (byte_data == CHAR_DOLAR) begin
               do_clear = 1'b1;
               phase_in = PH_BLK_NUM;
            end else begin
               do_fail = 1'b1;
            end
         end
         PH_BLK_SKIP: begin
            if (byte_data == CHAR_LF) phase_in = PH_BLK_HDR;
            else do_fail = 1'b1;
         end
         PH_BLK_NUM: begin
            if (byte_data == CHAR_CR) begin
               if (!digit_seen_ff) begin
                  do_fail = 1'b1;
               end else if (negative_ff) begin
                  if (accum_ff == '0) begin
                     negative_in   = 1'b0;
                     bytes_left_in = '0;
                     phase_in      = PH_BLK_LF;
                  end else if (accum_ff == ACCUM_BITS'(1)) begin
                     bytes_left_in = '0;
                     phase_in      = PH_BLK_LF;
                  end else begin
                     do_fail = 1'b1;
                  end
               end else if (accum_ext > {2'd0, max_bulk_length_ff} ||
                            accum_ext > LENGTH_MAX) begin
                  do_fail = 1'b1;
               end else begin
                  bytes_left_in = LENGTH_BITS'(accum_ff);
                  phase_in      = PH_BLK_LF;
               end
            end else if (!take_ok) begin
               do_fail = 1'b1;
            end
         end
         PH_BLK_LF: begin
            if (byte_data != CHAR_LF) begin
               do_fail = 1'b1;
            end else if (negative_ff) begin
               do_arg_end = 1'b1;
               arg_nul    = 1'b1;
            end else begin
               phase_in = (bytes_left_ff == '0) ? PH_DATA_CR : PH_DATA;
            end
         end
         PH_DATA: begin
            bytes_left_in = bytes_dec;
            if (bytes_dec == '0) phase_in = PH_DATA_CR;
            res_valid     = 1'b1;
            res.kind      = KIND_DATA;
            res.data_byte = byte_data;
         end
         PH_DATA_CR: begin
            if (byte_data == CHAR_CR) phase_in = PH_DATA_LF;
            else do_fail = 1'b1;
         end
         PH_DATA_LF: begin
            if (byte_data == CHAR_LF) do_arg_end = 1'b1;
            else do_fail = 1'b1;
         end
         default: do_fail = 1'b1;
      endcase

      if (do_arg_end) begin
         res_valid       = 1'b1;
         res.kind        = KIND_END;
         res.null_arg    = arg_nul;
         res.command_end = last_arg;
         if (last_arg) begin
            do_restart = 1'b1;
         end else begin
            args_done_in  = done_plus[COUNT_BITS-1:0];
            phase_in      = PH_BLK_HDR;
            do_clear      = 1'b1;
            bytes_left_in = '0;
         end
      end

      if (do_fail) begin
         res_valid       = 1'b1;
         res.kind        = KIND_ERR;
         res.data_byte   = 8'h00;
         res.arg_index   = 16'(args_done_ff);
         res.null_arg    = 1'b0;
         res.command_end = 1'b0;
         do_restart      = 1'b1;
      end

      if (do_restart) begin
         phase_in         = PH_ARR_HDR;
         do_clear         = 1'b1;
         args_expected_in = '0;
         args_done_in     = '0;
         bytes_left_in    = '0;
      end

      if (do_clear) begin
         accum_in        = '0;
         negative_in     = 1'b0;
         digit_seen_in   = 1'b0;
         line_started_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_arg_count_ff   <= MAX_ARG_COUNT_RESET;
         max_bulk_length_ff <= MAX_BULK_LENGTH_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_MAX_ARG_COUNT) max_arg_count_ff <= csr_wdata[15:0];
         if (csr_index == CSR_MAX_BULK_LENGTH) max_bulk_length_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_ARR_HDR;
         accum_ff         <= '0;
         negative_ff      <= 1'b0;
         digit_seen_ff    <= 1'b0;
         line_started_ff  <= 1'b0;
         args_expected_ff <= '0;
         args_done_ff     <= '0;
         bytes_left_ff    <= '0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         accum_ff         <= accum_in;
         negative_ff      <= negative_in;
         digit_seen_ff    <= digit_seen_in;
         line_started_ff  <= line_started_in;
         args_expected_ff <= args_expected_in;
         args_done_ff     <= args_done_in;
         bytes_left_ff    <= bytes_left_in;
      end
   end

endmodule

### src/rcp_out_reg.sv
// Result register: holds one parser result until the consumer takes it.
module rcp_out_reg
   import rcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       res_valid,
   input  result_type res,
   output logic       out_free,
   rcp_rsp_if.source  rsp
);

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign out_free = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (advance) begin
         valid_in = res_valid;
         res_in   = res;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp.valid       = valid_ff;
   assign rsp.kind        = res_ff.kind;
   assign rsp.data_byte   = res_ff.data_byte;
   assign rsp.arg_index   = res_ff.arg_index;
   assign rsp.null_arg    = res_ff.null_arg;
   assign rsp.command_end = res_ff.command_end;

endmodule

### src/resp_command_parser_top.sv
// Top level of the RESP command parser.
//
//   channel   dir  handshake            payload
//   req_port  in   valid/ready          in_byte
//   rsp_port  out  valid/ready          kind, data_byte, arg_index, null_arg, command_end
//   csr_*     in   csr_we (no stall)    csr_index, csr_wdata
//
// One byte per cycle sustained while rsp_port does not stall; each byte passes the input
// register, the parse logic (phase FSM, x10 accumulator, limit compares) and the result
// register. A byte that gives no result leaves no item on rsp_port.
// Synchronous active-high reset restores the start phase and the default limits.
// A stall on rsp_port holds the parser; req_port stays ready while the input register
// is empty or drains in the same cycle.
module resp_command_parser_top
   import rcp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   rcp_req_if.sink                   req_port,
   rcp_rsp_if.source                 rsp_port,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic       byte_valid;
   logic [7:0] byte_data;
   logic       out_free;
   logic       advance;
   logic       res_valid;
   result_type res;

   assign advance = byte_valid && out_free;

   rcp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req        (req_port),
      .advance    (advance),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   rcp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (advance),
      .byte_data (byte_data),
      .res_valid (res_valid),
      .res       (res)
   );

   rcp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp       (rsp_port)
   );

endmodule

### bench/tb_resp_command_parser_top.sv
// Testbench for resp_command_parser_top: directed and random RESP streams checked by a model.
`timescale 1ns / 100ps

module tb_resp_command_parser_top;
   import rcp_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   class resp_result_book;
      logic [15:0] max_count;
      logic [30:0] max_len;
      logic [3:0]  phase;
      logic [31:0] accum;
      bit          negative;
      bit          digit_seen;
      bit          line_started;
      logic [15:0] args_expected;
      logic [15:0] args_done;
      logic [31:0] bytes_left;
      result_type  due[$];
      int          mismatches;

      function new();
         max_count  = MAX_ARG_COUNT_RESET;
         max_len    = MAX_BULK_LENGTH_RESET;
         mismatches = 0;
         restart();
      endfunction

      function void clear_line();
         accum        = '0;
         negative     = 1'b0;
         digit_seen   = 1'b0;
         line_started = 1'b0;
      endfunction

      function void restart();
         phase = PH_ARR_HDR;
         clear_line();
         args_expected = '0;
         args_done     = '0;
         bytes_left    = '0;
      endfunction

      function void set_limit(logic [7:0] index, logic [30:0] value);
         if (index == CSR_MAX_ARG_COUNT) begin
            max_count = value[15:0];
         end else if (index == CSR_MAX_BULK_LENGTH) begin
            max_len = value;
         end
      endfunction

      function void post(logic [1:0] kind, logic [7:0] data, logic [15:0] idx, bit nul, bit fin);
         result_type r;
         r.kind        = kind;
         r.data_byte   = data;
         r.arg_index   = idx;
         r.null_arg    = nul;
         r.command_end = fin;
         due.push_back(r);
      endfunction

      function void flag_error();
         logic [15:0] idx;
         idx = args_done;
         restart();
         post(KIND_ERR, 8'h00, idx, 1'b0, 1'b0);
      endfunction

      function bit take_char(logic [7:0] b);
         logic [63:0] v;
         if (b == CHAR_MINUS && !line_started) begin
            negative     = 1'b1;
            line_started = 1'b1;
            return 1'b1;
         end
         if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            v = 64'(accum) * 64'd10 + 64'(b - CHAR_ZERO);
            accum        = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
            digit_seen   = 1'b1;
            line_started = 1'b1;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void close_arg(bit nul);
         logic [15:0] idx;
         bit          last;
         idx  = args_done;
         last = ({1'b0, args_done} + 17'd1) == {1'b0, args_expected};
         if (last) begin
            restart();
         end else begin
            args_done  = args_done + 16'd1;
            phase      = PH_BLK_HDR;
            clear_line();
            bytes_left = '0;
         end
         post(KIND_END, 8'h00, idx, nul, last);
      endfunction

      function void take_byte(logic [7:0] b);
         case (phase)
            PH_ARR_HDR: begin
               if (b == CHAR_CR) begin
                  phase = PH_ARR_SKIP;
               end else if (b != CHAR_STAR) begin
                  flag_error();
               end else begin
                  clear_line();
                  phase = PH_ARR_NUM;
               end
            end
            PH_ARR_SKIP: begin
               if (b != CHAR_LF) flag_error();
               else phase = PH_ARR_HDR;
            end
            PH_ARR_NUM: begin
               if (b == CHAR_CR) begin
                  if (!digit_seen || (negative && accum != 0) || accum > {16'd0, max_count}) begin
                     flag_error();
                  end else begin
                     args_expected = accum[15:0];
                     phase = PH_ARR_LF;
                  end
               end else if (!take_char(b)) begin
                  flag_error();
               end
            end
            PH_ARR_LF: begin
               if (b != CHAR_LF) begin
                  flag_error();
               end else if (args_expected == 0) begin
                  restart();
                  post(KIND_EMPTY, 8'h00, 16'd0, 1'b0, 1'b1);
               end else begin
                  args_done = '0;
                  clear_line();
                  phase = PH_BLK_HDR;
               end
            end
            PH_BLK_HDR: begin
               if (b == CHAR_CR) begin
                  phase = PH_BLK_SKIP;
               end else if (b != CHAR_DOLAR) begin
                  flag_error();
               end else begin
                  clear_line();
                  phase = PH_BLK_NUM;
               end
            end
            PH_BLK_SKIP: begin
               if (b != CHAR_LF) flag_error();
               else phase = PH_BLK_HDR;
            end
            PH_BLK_NUM: begin
               if (b == CHAR_CR) begin
                  if (!digit_seen || (negative && accum > 1)
                      || (!negative && accum > {1'b0, max_len})) begin
                     flag_error();
                  end else begin
                     if (accum == 0) negative = 1'b0;
                     bytes_left = negative ? 32'd0 : accum;
                     phase = PH_BLK_LF;
                  end
               end else if (!take_char(b)) begin
                  flag_error();
               end
            end
            PH_BLK_LF: begin
               if (b != CHAR_LF) flag_error();
               else if (negative) close_arg(1'b1);
               else phase = (bytes_left == 0) ? PH_DATA_CR : PH_DATA;
            end
            PH_DATA: begin
               bytes_left = bytes_left - 32'd1;
               if (bytes_left == 0) phase = PH_DATA_CR;
               post(KIND_DATA, b, args_done, 1'b0, 1'b0);
            end
            PH_DATA_CR: begin
               if (b != CHAR_CR) flag_error();
               else phase = PH_DATA_LF;
            end
            PH_DATA_LF: begin
               if (b != CHAR_LF) flag_error();
               else close_arg(1'b0);
            end
            default: flag_error();
         endcase
      endfunction

      function void match_result(result_type got);
         result_type want;
         if (due.size() == 0) begin
            $display("%0t: unexpected result kind=%0d data=%02h arg=%0d null=%0b end=%0b",
                     $time, got.kind, got.data_byte, got.arg_index, got.null_arg,
                     got.command_end);
            mismatches++;
            return;
         end
         want = due.pop_front();
         if (got !== want) begin
            $display("%0t: expected kind=%0d data=%02h arg=%0d null=%0b end=%0b",
                     $time, want.kind, want.data_byte, want.arg_index, want.null_arg,
                     want.command_end);
            $display("%0t:   actual kind=%0d data=%02h arg=%0d null=%0b end=%0b",
                     $time, got.kind, got.data_byte, got.arg_index, got.null_arg,
                     got.command_end);
            mismatches++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;
   bit                        idle_on;
   int                        bytes_sent;
   int                        cycles;
   int                        stall_left;
   resp_result_book           book = new();

   rcp_req_if req_if();
   rcp_rsp_if rsp_if();

   resp_command_parser_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_if),
      .rsp_port  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // results are checked before the byte of the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            book.match_result({rsp_if.kind, rsp_if.data_byte, rsp_if.arg_index,
                               rsp_if.null_arg, rsp_if.command_end});
         end
         if (req_if.valid && req_if.ready) book.take_byte(req_if.in_byte);
      end
   end

   initial begin
      rsp_if.ready <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic send_byte(logic [7:0] b);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.in_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   function automatic void append_text(ref logic [7:0] q[$], input string s);
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
   endfunction

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (book.due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(logic [7:0] index, logic [30:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      book.set_limit(index, value);
      @(posedge clock);
   endtask

   // well-formed command with random content, sometimes corrupted or cut short
   task automatic send_random_command(int count_cap, int len_cap);
      logic [7:0] frame[$];
      int         n;
      int         len;
      int         cut;
      string      txt;
      n = $urandom_range(0, count_cap);
      if ($urandom_range(0, 9) == 0) append_text(frame, "\015\012");
      txt = (n == 0 && $urandom_range(0, 3) == 0) ? "-0" : $sformatf("%0d", n);
      if ($urandom_range(0, 9) == 0) txt = {"0", txt};
      append_text(frame, "*");
      append_text(frame, txt);
      append_text(frame, "\015\012");
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 19) == 0) append_text(frame, "\015\012");
         if ($urandom_range(0, 6) == 0) begin
            append_text(frame, "$-1\015\012");
         end else begin
            len = $urandom_range(0, len_cap);
            txt = $sformatf("%0d", len);
            append_text(frame, "$");
            append_text(frame, txt);
            append_text(frame, "\015\012");
            repeat (len) frame.push_back(8'($urandom_range(0, 255)));
            append_text(frame, "\015\012");
         end
      end
      if ($urandom_range(0, 7) == 0) begin
         cut = $urandom_range(0, frame.size() - 1);
         if ($urandom_range(0, 1) == 1) frame[cut] = 8'($urandom_range(0, 255));
         else frame = frame[0:cut];
      end
      foreach (frame[i]) send_byte(frame[i]);
   endtask

   task automatic run_random(int count, int count_cap, int len_cap);
      int stop_at;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) begin
         if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
         end else begin
            send_random_command(count_cap, len_cap);
         end
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.in_byte <= 8'h00;
      csr_we         <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      idle_on    = 1'b1;
      bytes_sent = 0;
      cycles     = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // well-formed commands
      send_text("*1\015\012$3\015\012abc\015\012");
      send_text("*0\015\012");
      send_text("*-0\015\012");
      send_text("*2\015\012$-1\015\012$-0\015\012\015\012");
      send_text("\015\012*001\015\012\015\012$-01\015\012");
      send_text("*1\015\012$4\015\012\015\012*\377\015\012");
      send_text("*1\015\012$1\015\012");
      send_byte(8'h00);
      send_text("\015\012");
      // malformed input
      send_text("X");
      send_text("*1\015\012*");
      send_text("$");
      send_text("*\015");
      send_text("*1-");
      send_text("*--");
      send_text("*-1\015");
      send_text("*1\015X");
      send_text("\015X");
      send_text("*2\015\012\015X");
      send_text("*2\015\012$-1\015\012$-2\015");
      send_text("*1\015\012$2\015\012ab\012");
      send_text("*1\015\012$2\015\012ab\015X");
      send_text("*1\015\012$1x");
      send_text("*1025\015");

      // tightest limits
      drain();
      write_limit(CSR_MAX_ARG_COUNT, 31'd1);
      write_limit(CSR_MAX_BULK_LENGTH, 31'd0);
      send_text("*2\015");
      send_text("*1\015\012$1\015");
      send_text("*1\015\012$0\015\012\015\012");

      // widest limits, overflow and saturation
      drain();
      write_limit(CSR_MAX_ARG_COUNT, 31'd65535);
      write_limit(CSR_MAX_BULK_LENGTH, 31'h7FFF_FFFF);
      send_text("*65536\015");
      send_text("*99999999999\015");
      send_text("*1\015\012$2147483648\015");
      send_text("*1\015\012$99999999999\015");
      send_text("*65535\015\012$-1\015\012$-1\015\012X");

      drain();
      write_limit(CSR_MAX_ARG_COUNT, 31'($urandom_range(3, 8)));
      write_limit(CSR_MAX_BULK_LENGTH, 31'($urandom_range(4, 12)));
      run_random(120, int'(book.max_count) + 1, int'(book.max_len) + 2);
      drain();
      run_random(110, int'(book.max_count) + 1, int'(book.max_len) + 2);

      drain();
      write_limit(CSR_MAX_ARG_COUNT, 31'd1);
      write_limit(CSR_MAX_BULK_LENGTH, 31'd0);
      run_random(140, 2, 2);

      drain();
      write_limit(CSR_MAX_ARG_COUNT, 31'd65535);
      write_limit(CSR_MAX_BULK_LENGTH, 31'h7FFF_FFFF);
      run_random(170, 6, 12);

      drain();
      write_limit(CSR_MAX_ARG_COUNT, 31'($urandom_range(9, 65535)));
      write_limit(CSR_MAX_BULK_LENGTH, 31'($urandom_range(13, 32'h7FFF_FFFF)));
      run_random(60, 6, 12);
      idle_on = 1'b0;
      run_random(100, 6, 12);

      drain();
      if (book.mismatches == 0 && book.due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### sim.f
src/rcp_pkg.sv
src/rcp_ifs.sv
src/rcp_in_reg.sv
src/rcp_core.sv
src/rcp_out_reg.sv
src/resp_command_parser_top.sv
bench/tb_resp_command_parser_top.sv
